/* hdl/i2cs_pkg.sv */
// Package for the I2C master transaction sequencer.
// Holds phase encoding, bus op / command / result codes and shared structs.
// No dependencies.
package i2cs_pkg;

  // phase of the transaction, one-hot
  typedef enum logic [8:0] {
    PH_IDLE   = 9'b0_0000_0001,
    PH_WSTART = 9'b0_0000_0010,
    PH_WADDR  = 9'b0_0000_0100,
    PH_WDATA  = 9'b0_0000_1000,
    PH_RSTART = 9'b0_0001_0000,
    PH_RADDR  = 9'b0_0010_0000,
    PH_RDATA  = 9'b0_0100_0000,
    PH_RLAST  = 9'b0_1000_0000,
    PH_STOP   = 9'b1_0000_0000
  } phase_t;

  // input commands
  localparam logic [1:0] CMD_BEGIN = 2'd0;
  localparam logic [1:0] CMD_STEP  = 2'd1;
  localparam logic [1:0] CMD_STOP  = 2'd2;

  // bus engine operations
  localparam logic [2:0] OP_NONE  = 3'd0;
  localparam logic [2:0] OP_START = 3'd1;
  localparam logic [2:0] OP_WRITE = 3'd2;
  localparam logic [2:0] OP_RACK  = 3'd3;
  localparam logic [2:0] OP_RNACK = 3'd4;
  localparam logic [2:0] OP_STOP  = 3'd5;

  // result codes
  localparam logic [2:0] RES_OK     = 3'd0;
  localparam logic [2:0] RES_START  = 3'd1;
  localparam logic [2:0] RES_WADDR  = 3'd2;
  localparam logic [2:0] RES_WDATA  = 3'd3;
  localparam logic [2:0] RES_RSTART = 3'd4;
  localparam logic [2:0] RES_RADDR  = 3'd5;
  localparam logic [2:0] RES_RDATA  = 3'd6;
  localparam logic [2:0] RES_RLAST  = 3'd7;

  // bus engine status codes (after masking)
  localparam logic [7:0] STATUS_MASK   = 8'hF8;
  localparam logic [7:0] ST_START      = 8'h08;
  localparam logic [7:0] ST_RESTART    = 8'h10;
  localparam logic [7:0] ST_WADDR_ACK  = 8'h18;
  localparam logic [7:0] ST_WDATA_ACK  = 8'h28;
  localparam logic [7:0] ST_RADDR_ACK  = 8'h40;
  localparam logic [7:0] ST_RDATA_ACK  = 8'h50;
  localparam logic [7:0] ST_RDATA_NACK = 8'h58;

  typedef struct packed {
    logic [1:0] cmd;
    logic [7:0] addr_byte;
    logic [7:0] send_count;
    logic [7:0] recv_count;
    logic [7:0] bus_status;
    logic [7:0] rx_byte;
    logic [7:0] tx_byte;
  } item_t;

  typedef struct packed {
    phase_t     phase;
    logic [7:0] byte_counter;
    logic [7:0] saved_address;
    logic [7:0] saved_send_count;
    logic [7:0] saved_recv_count;
  } ctx_t;

  typedef struct packed {
    logic [2:0] bus_op;
    logic [7:0] bus_byte;
    logic [7:0] send_index;
    logic       rx_valid;
    logic [7:0] rx_data;
    logic [7:0] rx_index;
    logic       done_res;
    logic [2:0] result;
  } res_t;

endpackage

/* hdl/i2cs_step.sv */
// Next-state and result logic for one word of the transaction sequencer.
// Depends on i2cs_pkg.
module i2cs_step (
  input  i2cs_pkg::item_t item,
  input  i2cs_pkg::ctx_t  cur,
  output i2cs_pkg::ctx_t  nxt,
  output i2cs_pkg::res_t  res
);

  logic [7:0] st;
  logic [7:0] bc_inc;
  logic       more_reads;

  assign st     = item.bus_status & i2cs_pkg::STATUS_MASK;
  assign bc_inc = cur.byte_counter + 8'd1;

  // read issue decision: in RADDR the counter restarts at zero, in RDATA it advances
  always_comb begin
    if (cur.phase == i2cs_pkg::PH_RDATA) begin
      more_reads = ({1'b0, bc_inc} + 9'd1) < {1'b0, cur.saved_recv_count};
    end else begin
      more_reads = 9'd1 < {1'b0, cur.saved_recv_count};
    end
  end

  always_comb begin
    nxt = cur;
    res = '0;
    case (item.cmd)
      i2cs_pkg::CMD_BEGIN: begin
        if (cur.phase == i2cs_pkg::PH_IDLE) begin
          nxt.saved_address    = item.addr_byte;
          nxt.saved_send_count = item.send_count;
          nxt.saved_recv_count = item.recv_count;
          nxt.byte_counter     = '0;
          if (item.send_count != 8'd0) begin
            res.bus_op = i2cs_pkg::OP_START;
            nxt.phase  = i2cs_pkg::PH_WSTART;
          end else if (item.recv_count != 8'd0) begin
            res.bus_op = i2cs_pkg::OP_START;
            nxt.phase  = i2cs_pkg::PH_RSTART;
          end else begin
            res.bus_op = i2cs_pkg::OP_STOP;
            nxt.phase  = i2cs_pkg::PH_STOP;
          end
        end
      end
      i2cs_pkg::CMD_STOP: begin
        if (cur.phase == i2cs_pkg::PH_STOP) begin
          res.done_res     = 1'b1;
          nxt.phase        = i2cs_pkg::PH_IDLE;
          nxt.byte_counter = '0;
        end
      end
      i2cs_pkg::CMD_STEP: begin
        unique case (cur.phase)
          i2cs_pkg::PH_WSTART: begin
            if (st != i2cs_pkg::ST_START) begin
              res.result = i2cs_pkg::RES_START;
            end else begin
              res.bus_op       = i2cs_pkg::OP_WRITE;
              res.bus_byte     = cur.saved_address;
              nxt.byte_counter = '0;
              nxt.phase        = i2cs_pkg::PH_WADDR;
            end
          end
          i2cs_pkg::PH_WADDR: begin
            if (st != i2cs_pkg::ST_WADDR_ACK) begin
              res.result = i2cs_pkg::RES_WADDR;
            end else begin
              res.bus_op       = i2cs_pkg::OP_WRITE;
              res.bus_byte     = item.tx_byte;
              nxt.byte_counter = 8'd1;
              nxt.phase        = i2cs_pkg::PH_WDATA;
            end
          end
          i2cs_pkg::PH_WDATA: begin
            if (st != i2cs_pkg::ST_WDATA_ACK) begin
              res.result = i2cs_pkg::RES_WDATA;
            end else if (cur.byte_counter < cur.saved_send_count) begin
              res.bus_op       = i2cs_pkg::OP_WRITE;
              res.bus_byte     = item.tx_byte;
              nxt.byte_counter = bc_inc;
            end else if (cur.saved_recv_count != 8'd0) begin
              res.bus_op       = i2cs_pkg::OP_START;
              nxt.phase        = i2cs_pkg::PH_RSTART;
              nxt.byte_counter = '0;
            end else begin
              res.bus_op       = i2cs_pkg::OP_STOP;
              nxt.phase        = i2cs_pkg::PH_STOP;
              nxt.byte_counter = '0;
            end
          end
          i2cs_pkg::PH_RSTART: begin
            if (st != i2cs_pkg::ST_START && st != i2cs_pkg::ST_RESTART) begin
              res.result = i2cs_pkg::RES_RSTART;
            end else begin
              res.bus_op   = i2cs_pkg::OP_WRITE;
              res.bus_byte = cur.saved_address | 8'd1;
              nxt.phase    = i2cs_pkg::PH_RADDR;
            end
          end
          i2cs_pkg::PH_RADDR: begin
            if (st != i2cs_pkg::ST_RADDR_ACK) begin
              res.result = i2cs_pkg::RES_RADDR;
            end else begin
              nxt.byte_counter = '0;
              res.bus_op = more_reads ? i2cs_pkg::OP_RACK : i2cs_pkg::OP_RNACK;
              nxt.phase  = more_reads ? i2cs_pkg::PH_RDATA : i2cs_pkg::PH_RLAST;
            end
          end
          i2cs_pkg::PH_RDATA: begin
            if (st != i2cs_pkg::ST_RDATA_ACK) begin
              res.result = i2cs_pkg::RES_RDATA;
            end else begin
              res.rx_valid     = 1'b1;
              res.rx_data      = item.rx_byte;
              res.rx_index     = cur.byte_counter;
              nxt.byte_counter = bc_inc;
              res.bus_op = more_reads ? i2cs_pkg::OP_RACK : i2cs_pkg::OP_RNACK;
              nxt.phase  = more_reads ? i2cs_pkg::PH_RDATA : i2cs_pkg::PH_RLAST;
            end
          end
          i2cs_pkg::PH_RLAST: begin
            if (st != i2cs_pkg::ST_RDATA_NACK) begin
              res.result = i2cs_pkg::RES_RLAST;
            end else begin
              res.rx_valid     = 1'b1;
              res.rx_data      = item.rx_byte;
              res.rx_index     = cur.byte_counter;
              res.bus_op       = i2cs_pkg::OP_STOP;
              nxt.byte_counter = '0;
              nxt.phase        = i2cs_pkg::PH_STOP;
            end
          end
          default: begin
          end
        endcase
        // any nonzero result code here is a status mismatch: stop and end at once
        if (res.result != i2cs_pkg::RES_OK) begin
          res.bus_op       = i2cs_pkg::OP_STOP;
          res.done_res     = 1'b1;
          nxt.phase        = i2cs_pkg::PH_IDLE;
          nxt.byte_counter = '0;
        end
      end
      default: begin
      end
    endcase
    if (nxt.phase == i2cs_pkg::PH_WADDR || nxt.phase == i2cs_pkg::PH_WDATA) begin
      res.send_index = nxt.byte_counter;
    end
  end

endmodule

/* hdl/i2c_master_transaction_sequencer_core.sv */
// Top level of the I2C master write-then-read transaction sequencer.
// Depends on i2cs_pkg and i2cs_step.
//
// Every input word (begin, engine step finished, stop finished) yields exactly one
// result word. A word is captured in an input register, evaluated by one pass of
// combinational step logic against the transaction state, and the result lands in
// an output register in the same cycle as the state update. Throughput is one word
// per clock while out_ready stays high. An accepted word moves from the input
// register to the output register and is held there until taken. While a result
// waits there, the input register can take one more word and then holds it.
module i2c_master_transaction_sequencer_core (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] in_cmd,
  input  logic [7:0] in_addr_byte,
  input  logic [7:0] in_send_count,
  input  logic [7:0] in_recv_count,
  input  logic [7:0] in_bus_status,
  input  logic [7:0] in_rx_byte,
  input  logic [7:0] in_tx_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [2:0] out_bus_op,
  output logic [7:0] out_bus_byte,
  output logic [7:0] out_send_index,
  output logic       out_rx_valid,
  output logic [7:0] out_rx_data,
  output logic [7:0] out_rx_index,
  output logic       out_done_res,
  output logic [2:0] out_result
);

  logic            s1_valid_r;
  i2cs_pkg::item_t s1_item_r;
  logic            s1_adv;
  logic            out_valid_r;
  i2cs_pkg::res_t  out_res_r;
  i2cs_pkg::ctx_t  ctx_r;
  i2cs_pkg::ctx_t  ctx_nxt;
  i2cs_pkg::res_t  res_nxt;

  assign s1_adv   = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_adv;

  i2cs_step u_step (
    .item (s1_item_r),
    .cur  (ctx_r),
    .nxt  (ctx_nxt),
    .res  (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_item_r <= '{cmd: in_cmd, addr_byte: in_addr_byte, send_count: in_send_count,
                     recv_count: in_recv_count, bus_status: in_bus_status,
                     rx_byte: in_rx_byte, tx_byte: in_tx_byte};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctx_r.phase            <= i2cs_pkg::PH_IDLE;
      ctx_r.byte_counter     <= '0;
      ctx_r.saved_address    <= '0;
      ctx_r.saved_send_count <= '0;
      ctx_r.saved_recv_count <= '0;
    end else if (s1_adv) begin
      ctx_r <= ctx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_res_r <= res_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_bus_op     = out_res_r.bus_op;
  assign out_bus_byte   = out_res_r.bus_byte;
  assign out_send_index = out_res_r.send_index;
  assign out_rx_valid   = out_res_r.rx_valid;
  assign out_rx_data    = out_res_r.rx_data;
  assign out_rx_index   = out_res_r.rx_index;
  assign out_done_res   = out_res_r.done_res;
  assign out_result     = out_res_r.result;

`ifndef SYNTHESIS
  // idle always leaves the byte counter cleared
  a_idle_counter: assert property (@(posedge clk) disable iff (!rst_n)
    ctx_r.phase == i2cs_pkg::PH_IDLE |-> ctx_r.byte_counter == 8'd0)
    else $error("byte counter nonzero while idle");

  // write counter never runs past the send count
  a_wdata_bound: assert property (@(posedge clk) disable iff (!rst_n)
    ctx_r.phase == i2cs_pkg::PH_WDATA |-> ctx_r.byte_counter <= ctx_r.saved_send_count)
    else $error("write counter beyond send count");

  // a received byte always comes with the next read or the final stop
  a_rx_with_op: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_res_r.rx_valid |->
      out_res_r.bus_op == i2cs_pkg::OP_RACK || out_res_r.bus_op == i2cs_pkg::OP_RNACK ||
      out_res_r.bus_op == i2cs_pkg::OP_STOP)
    else $error("received byte without follow-up bus op");

  // an error code only appears with done and a stop
  a_err_stop: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_res_r.result != i2cs_pkg::RES_OK |->
      out_res_r.done_res && out_res_r.bus_op == i2cs_pkg::OP_STOP)
    else $error("error result without done and stop");

  // a word held in the input register is not lost while the output stalls
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !s1_adv |=> s1_valid_r && $stable(s1_item_r))
    else $error("stalled input word dropped or changed");
`endif

endmodule
